/* rtl/scc_pkg.sv */
// ----------------------------------------------------------------------------
// scc_pkg: spectrogram column colorizer package
// Shared widths, design constants, register indexes, handshake structs and the
// color table lookup.
// ----------------------------------------------------------------------------
package scc_pkg;

   // design constants
   localparam int MAX_ROWS     = 256;
   localparam int SCALE_OFFSET = 20;
   localparam int X_TICKS      = 8;
   localparam int Y_TICKS      = 8;

   // field widths
   localparam int MAG_W    = 16;
   localparam int AMPL_W   = 15;
   localparam int COLOR_W  = 16;
   localparam int ROW_W    = 8;
   localparam int COL_W    = 10;
   localparam int ROWS_W   = 9;
   localparam int SQ_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // arithmetic widths
   localparam int SUM_W   = 18;
   localparam int LIM_W   = AMPL_W + 2;
   localparam int QBITS   = 5;
   localparam int NUM_W   = SUM_W + QBITS;
   localparam int STEP_W  = 3;
   localparam int MARK_W  = 16;
   localparam int PAL_N   = 17;

   localparam logic [QBITS-1:0] IDX_MAX  = QBITS'(PAL_N - 1);
   localparam logic [SQ_W-1:0]  SQ_MAX   = SQ_W'(4);

   // reset values of the configuration registers
   localparam logic [ROWS_W-1:0]  ROWS_RST       = ROWS_W'(128);
   localparam logic [SQ_W-1:0]    SQUEEZE_RST    = SQ_W'(1);
   localparam logic [COL_W-1:0]   PLOT_WIDTH_RST = COL_W'(320);
   localparam logic [COLOR_W-1:0] GRID_COLOR_RST = COLOR_W'(16904);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROWS       = 2'd0,
      REG_SQUEEZE    = 2'd1,
      REG_PLOT_WIDTH = 2'd2,
      REG_GRID_COLOR = 2'd3
   } reg_index_type;

   // request to the divider
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sum;
      logic [LIM_W-1:0] limit;
   } div_req_type;

   // answer of the divider
   typedef struct packed {
      logic             done;
      logic [QBITS-1:0] index;
   } div_rsp_type;

   // grid marks for one pixel
   typedef struct packed {
      logic tick;
      logic grid;
   } mark_type;

   // color table, RGB565
   localparam logic [COLOR_W-1:0] PALETTE [PAL_N] = '{
      16'h0000, 16'h0002, 16'h0004, 16'h0010, 16'h0038, 16'h00F8, 16'h01D8,
      16'h0238, 16'h0438, 16'h0730, 16'h07F0, 16'h0FC0, 16'h2F40, 16'hFFC0,
      16'hFF00, 16'hFD00, 16'hFC00
   };

   function automatic logic [COLOR_W-1:0] palette_color(input logic [QBITS-1:0] idx);
      logic [QBITS-1:0] sel;
      sel = (idx > IDX_MAX) ? IDX_MAX : idx;
      return PALETTE[sel];
   endfunction

endpackage

/* rtl/scc_if.sv */
// ----------------------------------------------------------------------------
// scc channel interfaces
// Valid/ready channels for bins, pixels and register writes.
// ----------------------------------------------------------------------------

// bin channel
interface scc_req_if;
   logic                        valid;
   logic                        ready;
   logic [scc_pkg::MAG_W-1:0]   magnitude;
   logic [scc_pkg::AMPL_W-1:0]  max_ampl;

   modport source (output valid, magnitude, max_ampl, input ready);
   modport sink   (input valid, magnitude, max_ampl, output ready);
endinterface

// pixel channel
interface scc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [scc_pkg::COLOR_W-1:0]  pixel_color;
   logic [scc_pkg::ROW_W-1:0]    row;
   logic [scc_pkg::COL_W-1:0]    column;
   logic                         last_in_column;

   modport source (output valid, pixel_color, row, column, last_in_column, input ready);
   modport sink   (input valid, pixel_color, row, column, last_in_column, output ready);
endinterface

// register write channel
interface scc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [scc_pkg::CSR_IDX_W-1:0]   index;
   logic [scc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/scc_shade_div.sv */
// ----------------------------------------------------------------------------
// scc_shade_div: color index divider
// Computes min(floor(sum*17/limit), 16) with one restoring subtract step per
// cycle over five quotient bits.
// ----------------------------------------------------------------------------
module scc_shade_div (
   input  logic                 clock,
   input  logic                 reset,
   input  scc_pkg::div_req_type div_req,
   output scc_pkg::div_rsp_type div_rsp
);
   import scc_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             clamp_ff, clamp_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [LIM_W-1:0] den_ff, den_in;
   logic [QBITS-1:0] q_ff, q_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] trial;

   // shifted divisor for the current quotient bit
   assign trial = NUM_W'(den_ff) << cnt_ff;

   // load on start, then one compare and subtract per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      clamp_in = clamp_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         num_in   = NUM_W'({div_req.sum, 4'b0000}) + NUM_W'(div_req.sum);
         den_in   = div_req.limit;
         clamp_in = (div_req.sum >= SUM_W'(div_req.limit));
         q_in     = '0;
         cnt_in   = STEP_W'(QBITS - 1);
      end else if (busy_ff) begin
         if (num_ff >= trial) begin
            num_in       = num_ff - trial;
            q_in[cnt_ff] = 1'b1;
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      clamp_ff <= clamp_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.index = clamp_ff ? IDX_MAX : q_ff;

endmodule

/* rtl/scc_grid_mark.sv */
// ----------------------------------------------------------------------------
// scc_grid_mark: tick column and grid row detection
// Compares the current column against the tick positions and the display row
// against the grid rows.
// ----------------------------------------------------------------------------
module scc_grid_mark (
   input  logic [scc_pkg::COL_W-1:0]  column_pos,
   input  logic [scc_pkg::COL_W-1:0]  plot_width,
   input  logic [scc_pkg::ROWS_W-1:0] disp,
   input  logic [scc_pkg::ROWS_W-1:0] nrows,
   output scc_pkg::mark_type          mark
);
   import scc_pkg::*;

   logic [COL_W-1:0] spacing;

   // tick spacing, zero for a narrow plot
   always_comb begin
      if (plot_width > COL_W'(SCALE_OFFSET))
         spacing = COL_W'((plot_width - COL_W'(SCALE_OFFSET)) / X_TICKS);
      else
         spacing = '0;
   end

   // tick columns at offset plus multiples of the spacing, grid rows at k*rows/Y_TICKS
   always_comb begin
      mark = '0;
      for (int i = 0; i < X_TICKS; i++) begin
         if (MARK_W'(spacing) * MARK_W'(i) + MARK_W'(SCALE_OFFSET) == MARK_W'(column_pos))
            mark.tick = 1'b1;
      end
      for (int k = 0; k < Y_TICKS; k++) begin
         if (MARK_W'((MARK_W'(k) * MARK_W'(nrows)) / Y_TICKS) == MARK_W'(disp))
            mark.grid = 1'b1;
      end
   end

endmodule

/* rtl/spectrogram_column_colorizer_top.sv */
// ----------------------------------------------------------------------------
// spectrogram_column_colorizer_top: spectrogram column colorizer
// Sums magnitude bins per display row, shades each row through the color
// table and emits one pixel item per row, with tick columns and grid rows.
//
//   channel  | dir | handshake          | payload
//   req_if   | in  | valid/ready        | magnitude, max_ampl
//   rsp_if   | out | valid/ready        | pixel_color, row, column, last_in_column
//   csr_if   | in  | valid/ready (=1)   | index, data
//
// a bin that completes no row leaves the block idle and ready for the next bin
// a bin that completes a row passes through load, five serial divider steps,
// divider result, pixel forming and the output state
// squeeze 0 gives two pixels, one if the first ends the column
// output stalls hold the output state; one item is worked at a time; req
// ready is low from a row's start until its last pixel is taken
// synchronous active-high reset restores register defaults and column start
// ----------------------------------------------------------------------------
module spectrogram_column_colorizer_top (
   input logic      clock,
   input logic      reset,
   scc_req_if.sink  req_if,
   scc_rsp_if.source rsp_if,
   scc_csr_if.sink  csr_if
);
   import scc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_PIX  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [ROWS_W-1:0]  rows_ff;
   logic [SQ_W-1:0]    squeeze_ff;
   logic [COL_W-1:0]   plot_width_ff;
   logic [COLOR_W-1:0] grid_color_ff;

   logic [COL_W-1:0]   column_pos_ff, column_pos_in;
   logic [ROW_W-1:0]   row_count_ff, row_count_in;
   logic [SUM_W-1:0]   bin_sum_ff, bin_sum_in;
   logic [SQ_W-1:0]    bins_taken_ff, bins_taken_in;
   logic               pair_ff, pair_in;
   logic [COLOR_W-1:0] color_ff, color_in;

   logic [COLOR_W-1:0] pix_color_ff, pix_color_in;
   logic [ROW_W-1:0]   pix_row_ff, pix_row_in;
   logic [COL_W-1:0]   pix_col_ff, pix_col_in;
   logic               pix_last_ff, pix_last_in;

   logic [ROWS_W-1:0]  nrows;
   logic [SQ_W-1:0]    sq;
   logic [SQ_W-1:0]    sq_lim;
   logic [SUM_W-1:0]   sum_new;
   logic [SQ_W-1:0]    bins_new;
   logic [ROWS_W-1:0]  disp;
   logic [ROWS_W-1:0]  row_next;
   logic [COL_W-1:0]   col_inc;
   logic               req_take;
   logic               rsp_take;

   div_req_type div_req;
   div_rsp_type div_rsp;
   mark_type    mark;

   // effective rows and squeeze
   always_comb begin
      if (rows_ff == '0)
         nrows = ROWS_W'(1);
      else if (rows_ff > ROWS_W'(MAX_ROWS))
         nrows = ROWS_W'(MAX_ROWS);
      else
         nrows = rows_ff;
      sq     = (squeeze_ff > SQ_MAX) ? SQ_MAX : squeeze_ff;
      sq_lim = (sq == '0) ? SQ_W'(1) : sq;
   end

   assign req_take = req_if.valid && req_if.ready;
   assign rsp_take = rsp_if.valid && rsp_if.ready;
   assign sum_new  = bin_sum_ff + SUM_W'(req_if.magnitude);
   assign bins_new = bins_taken_ff + 1'b1;
   assign disp     = nrows - ROWS_W'(1) - ROWS_W'(row_count_ff);
   assign row_next = ROWS_W'(row_count_ff) + ROWS_W'(1);
   assign col_inc  = column_pos_ff + 1'b1;

   // color index divider
   scc_shade_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // tick and grid marks
   scc_grid_mark u_mark (
      .column_pos (column_pos_ff),
      .plot_width (plot_width_ff),
      .disp       (disp),
      .nrows      (nrows),
      .mark       (mark)
   );

   // row sequencer
   always_comb begin
      state_in      = state_ff;
      column_pos_in = column_pos_ff;
      row_count_in  = row_count_ff;
      bin_sum_in    = bin_sum_ff;
      bins_taken_in = bins_taken_ff;
      pair_in       = pair_ff;
      color_in      = color_ff;
      pix_color_in  = pix_color_ff;
      pix_row_in    = pix_row_ff;
      pix_col_in    = pix_col_ff;
      pix_last_in   = pix_last_ff;
      div_req.start = 1'b0;
      div_req.sum   = sum_new;
      div_req.limit = LIM_W'(req_if.max_ampl) * LIM_W'(sq_lim);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (ROWS_W'(row_count_ff) >= nrows)
                  row_count_in = '0;
               if (sq == '0) begin
                  // one bin spans two rows, partial sum dropped
                  bin_sum_in    = '0;
                  bins_taken_in = '0;
                  pair_in       = 1'b1;
                  div_req.start = 1'b1;
                  div_req.sum   = SUM_W'(req_if.magnitude);
                  state_in      = ST_DIV;
               end else if (bins_new < sq) begin
                  bin_sum_in    = sum_new;
                  bins_taken_in = bins_new;
               end else begin
                  bin_sum_in    = '0;
                  bins_taken_in = '0;
                  pair_in       = 1'b0;
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               color_in = palette_color(div_rsp.index);
               state_in = ST_PIX;
            end
         end
         ST_PIX: begin
            // form the pixel and advance row and column
            pix_color_in = (mark.tick || mark.grid) ? grid_color_ff : color_ff;
            pix_row_in   = disp[ROW_W-1:0];
            pix_col_in   = column_pos_ff;
            pix_last_in  = (row_next >= nrows);
            if (row_next >= nrows) begin
               row_count_in  = '0;
               bin_sum_in    = '0;
               bins_taken_in = '0;
               pair_in       = 1'b0;
               column_pos_in = (col_inc > plot_width_ff) ? COL_W'(SCALE_OFFSET) : col_inc;
            end else begin
               row_count_in = row_next[ROW_W-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_take) begin
               if (pair_ff) begin
                  pair_in  = 1'b0;
                  state_in = ST_PIX;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rows_ff       <= ROWS_RST;
         squeeze_ff    <= SQUEEZE_RST;
         plot_width_ff <= PLOT_WIDTH_RST;
         grid_color_ff <= GRID_COLOR_RST;
         column_pos_ff <= COL_W'(SCALE_OFFSET);
         row_count_ff  <= '0;
         bin_sum_ff    <= '0;
         bins_taken_ff <= '0;
         pair_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         column_pos_ff <= column_pos_in;
         row_count_ff  <= row_count_in;
         bin_sum_ff    <= bin_sum_in;
         bins_taken_ff <= bins_taken_in;
         pair_ff       <= pair_in;
         if (csr_if.valid && csr_if.ready) begin
            unique case (reg_index_type'(csr_if.index))
               REG_ROWS:       rows_ff       <= csr_if.data[ROWS_W-1:0];
               REG_SQUEEZE:    squeeze_ff    <= csr_if.data[SQ_W-1:0];
               REG_PLOT_WIDTH: plot_width_ff <= csr_if.data[COL_W-1:0];
               REG_GRID_COLOR: grid_color_ff <= csr_if.data[COLOR_W-1:0];
               default:        ;
            endcase
         end
      end
   end

   // pixel payload registers
   always_ff @(posedge clock) begin
      color_ff     <= color_in;
      pix_color_ff <= pix_color_in;
      pix_row_ff   <= pix_row_in;
      pix_col_ff   <= pix_col_in;
      pix_last_ff  <= pix_last_in;
   end

   // channel outputs
   assign req_if.ready          = (state_ff == ST_IDLE);
   assign csr_if.ready          = 1'b1;
   assign rsp_if.valid          = (state_ff == ST_OUT);
   assign rsp_if.pixel_color    = pix_color_ff;
   assign rsp_if.row            = pix_row_ff;
   assign rsp_if.column         = pix_col_ff;
   assign rsp_if.last_in_column = pix_last_ff;

`ifndef SYNTH
   // a pixel on offer blocks new bins
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("bin accepted while a pixel is pending");

   // the partial bin count never passes the largest squeeze
   a_bins_bounded: assert property (@(posedge clock) disable iff (reset)
      bins_taken_ff < SQ_MAX)
      else $error("partial bin count out of range");

   // the divider answers only while the sequencer waits on it
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider result outside of divide state");

   // the last pixel of a column restarts the row count
   a_last_clears_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_if.last_in_column) |=> (row_count_ff == '0))
      else $error("row count not cleared after the last pixel");

   // a second pixel of a pair never follows the last pixel of a column
   a_pair_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.last_in_column) |-> !pair_ff)
      else $error("pixel pair continues past the column end");
`endif

endmodule

/* tb/sv/spectrogram_column_colorizer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrogram column colorizer checker
// Watches the register, bin and pixel channels, keeps its own copy of the
// registers and column state, predicts the pixels each accepted bin makes
// and compares every accepted pixel with the oldest prediction.
// ----------------------------------------------------------------------------
module spectrogram_column_colorizer_checker (
   input  logic clock,
   input  logic reset,
   scc_req_if   req_if,
   scc_rsp_if   rsp_if,
   scc_csr_if   csr_if,
   output int   fail_count,
   output int   pending
);
   import scc_pkg::*;

   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   column;
      logic               last_in_column;
   } pixel_type;

   pixel_type predicted_pixels[$];

   // mirrored registers
   logic [ROWS_W-1:0]  rows_reg;
   logic [SQ_W-1:0]    squeeze_reg;
   logic [COL_W-1:0]   plot_width_reg;
   logic [COLOR_W-1:0] grid_color_reg;

   // column state
   logic [COL_W-1:0] column_pos;
   int unsigned      row_count;
   logic [SUM_W-1:0] bin_sum;
   logic [SQ_W-1:0]  bins_taken;

   int reported;

   // rows out of range are clamped to 1..MAX_ROWS
   function automatic int unsigned rows_in_use();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
   endfunction

   // tick columns sit at equal spacing from the plot origin
   function automatic bit on_tick_column();
      int unsigned spacing;
      int unsigned i;
      spacing = 0;
      if (plot_width_reg > SCALE_OFFSET)
         spacing = (int'(plot_width_reg) - SCALE_OFFSET) / X_TICKS;
      for (i = 0; i < X_TICKS; i++)
         if (spacing * i + SCALE_OFFSET == column_pos) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit on_grid_row(input int unsigned disp, input int unsigned nrows);
      int unsigned k;
      for (k = 0; k < Y_TICKS; k++)
         if ((k * nrows) / Y_TICKS == disp) return 1'b1;
      return 1'b0;
   endfunction

   // color table index floor(level*17/limit), clamped, full scale on zero limit
   function automatic logic [COLOR_W-1:0] shade_of(input int unsigned level,
                                                   input int unsigned limit);
      int unsigned idx;
      if (limit == 0) return PALETTE[PAL_N-1];
      idx = (level * PAL_N) / limit;
      if (idx > PAL_N - 1) idx = PAL_N - 1;
      return PALETTE[idx];
   endfunction

   // one pixel for the current logical row, bottom row first
   task automatic emit_pixel(input logic [COLOR_W-1:0] shade, input bit tick,
                             input int unsigned nrows, output bit col_done);
      int unsigned disp;
      pixel_type   px;
      disp = nrows - 1 - row_count;
      px.color = (tick || on_grid_row(disp, nrows)) ? grid_color_reg : shade;
      row_count++;
      col_done = (row_count >= nrows);
      px.row = disp[ROW_W-1:0];
      px.column = column_pos;
      px.last_in_column = col_done;
      predicted_pixels.push_back(px);
      if (col_done) begin
         row_count = 0;
         bin_sum = '0;
         bins_taken = '0;
         column_pos = column_pos + 1'b1;
         if (column_pos > plot_width_reg) column_pos = COL_W'(SCALE_OFFSET);
      end
   endtask

   task automatic colorize_bin(input logic [MAG_W-1:0] mag, input logic [AMPL_W-1:0] ampl);
      int unsigned        nrows;
      int unsigned        sq;
      bit                 tick;
      bit                 col_done;
      logic [COLOR_W-1:0] shade;
      nrows = rows_in_use();
      sq = (squeeze_reg > SQ_MAX) ? SQ_MAX : squeeze_reg;
      tick = on_tick_column();
      // rows lowered below the current row restart the column
      if (row_count >= nrows) row_count = 0;
      if (sq == 0) begin
         // one bin spans two rows, any partial sum is dropped
         bin_sum = '0;
         bins_taken = '0;
         shade = shade_of(mag, ampl);
         emit_pixel(shade, tick, nrows, col_done);
         if (!col_done) emit_pixel(shade, tick, nrows, col_done);
         return;
      end
      bin_sum = bin_sum + mag;
      bins_taken = bins_taken + 1'b1;
      if (bins_taken < sq) return;
      shade = shade_of(bin_sum, int'(ampl) * sq);
      bin_sum = '0;
      bins_taken = '0;
      emit_pixel(shade, tick, nrows, col_done);
   endtask

   // watch the channels at each rising edge
   always @(posedge clock) begin
      pixel_type seen;
      pixel_type want;
      if (reset) begin
         rows_reg = ROWS_RST;
         squeeze_reg = SQUEEZE_RST;
         plot_width_reg = PLOT_WIDTH_RST;
         grid_color_reg = GRID_COLOR_RST;
         column_pos = COL_W'(SCALE_OFFSET);
         row_count = 0;
         bin_sum = '0;
         bins_taken = '0;
         predicted_pixels.delete();
         fail_count = 0;
         reported = 0;
      end else begin
         // register writes
         if (csr_if.valid && csr_if.ready) begin
            case (reg_index_type'(csr_if.index))
               REG_ROWS:       rows_reg = csr_if.data[ROWS_W-1:0];
               REG_SQUEEZE:    squeeze_reg = csr_if.data[SQ_W-1:0];
               REG_PLOT_WIDTH: plot_width_reg = csr_if.data[COL_W-1:0];
               REG_GRID_COLOR: grid_color_reg = csr_if.data[COLOR_W-1:0];
               default: ;
            endcase
         end
         // pixel compare against the oldest prediction
         if (rsp_if.valid && rsp_if.ready) begin
            seen.color = rsp_if.pixel_color;
            seen.row = rsp_if.row;
            seen.column = rsp_if.column;
            seen.last_in_column = rsp_if.last_in_column;
            if (predicted_pixels.size() == 0) begin
               fail_count++;
               if (reported < REPORT_MAX)
                  $display("%0t: unexpected pixel: color %h row %0d col %0d last %b",
                           $time, seen.color, seen.row, seen.column, seen.last_in_column);
               reported++;
            end else begin
               want = predicted_pixels.pop_front();
               if (seen.color !== want.color || seen.row !== want.row ||
                   seen.column !== want.column ||
                   seen.last_in_column !== want.last_in_column) begin
                  fail_count++;
                  if (reported < REPORT_MAX)
                     $display("%0t: mismatch exp %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                              $time, want.color, want.row, want.column,
                              want.last_in_column, seen.color, seen.row,
                              seen.column, seen.last_in_column);
                  reported++;
               end
            end
         end
         // accepted bin
         if (req_if.valid && req_if.ready) colorize_bin(req_if.magnitude, req_if.max_ampl);
      end
      pending = predicted_pixels.size();
   end

endmodule

/* tb/sv/spectrogram_column_colorizer_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrogram column colorizer testbench
// Drives register writes and magnitude bins into the colorizer with random
// gaps on both channels and one long pixel-side hold-off; the checker beside
// the block predicts and compares every pixel. Directed cases come first,
// then random register settings with mostly whole columns of random bins.
// ----------------------------------------------------------------------------
module spectrogram_column_colorizer_top_tb;
   import scc_pkg::*;

   localparam int ITEM_TARGET   = 520;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT       = 100;
   localparam int QUIET_LIMIT   = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int fail_count;
   int pending;
   int sent = 0;
   int quiet_cycles = 0;
   int req_calm = 0;

   scc_req_if req_ch ();
   scc_rsp_if rsp_ch ();
   scc_csr_if csr_ch ();

   spectrogram_column_colorizer_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   spectrogram_column_colorizer_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_ch),
      .rsp_if     (rsp_ch),
      .csr_if     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // gap before an item, with stretches of back-to-back items
   function automatic int pick_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic offer_bin(input logic [MAG_W-1:0] mag, input logic [AMPL_W-1:0] ampl);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.magnitude <= mag;
      req_ch.max_ampl <= ampl;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent++;
   endtask

   // wait until every predicted pixel is out and the block is quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // bins with a spread of color indexes, edges and zero limits
   task automatic offer_random_bin();
      logic [MAG_W-1:0]  mag;
      logic [AMPL_W-1:0] ampl;
      case ($urandom_range(0, 5))
         0: begin
            mag = MAG_W'($urandom);
            ampl = AMPL_W'($urandom);
         end
         1, 2: begin
            ampl = AMPL_W'($urandom_range(1, 2000));
            mag = MAG_W'($urandom_range(0, 2 * ampl));
         end
         3: begin
            mag = ($urandom_range(0, 1) == 0) ? '0 : '1;
            ampl = ($urandom_range(0, 3) == 0) ? '0 : AMPL_W'($urandom);
         end
         4: begin
            mag = MAG_W'($urandom_range(0, 64));
            ampl = AMPL_W'($urandom_range(0, 16));
         end
         default: begin
            ampl = AMPL_W'($urandom);
            mag = MAG_W'($urandom_range(0, ampl));
         end
      endcase
      offer_bin(mag, ampl);
   endtask

   // random register setting; reports bins per column under it
   task automatic pick_setting(output int per_column);
      logic [ROWS_W-1:0] rows;
      logic [SQ_W-1:0]   sq;
      logic [COL_W-1:0]  width;
      int                nrows;
      int                sq_eff;
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0:       rows = '0;
            1:       rows = ROWS_W'(MAX_ROWS);
            default: rows = ROWS_W'($urandom_range(MAX_ROWS + 1, 511));
         endcase
      end else begin
         rows = ROWS_W'($urandom_range(1, 12));
      end
      sq = SQ_W'($urandom);
      case ($urandom_range(0, 7))
         0, 1, 2: width = COL_W'($urandom_range(21, 40));
         3, 4:    width = COL_W'($urandom);
         5:       width = COL_W'(21);
         6:       width = '1;
         default: width = COL_W'($urandom_range(0, SCALE_OFFSET));
      endcase
      write_reg(REG_ROWS, CSR_DATA_W'(rows));
      write_reg(REG_SQUEEZE, CSR_DATA_W'(sq));
      write_reg(REG_PLOT_WIDTH, CSR_DATA_W'(width));
      write_reg(REG_GRID_COLOR, CSR_DATA_W'($urandom));
      nrows = (rows == 0) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : rows;
      sq_eff = (sq > SQ_MAX) ? SQ_MAX : sq;
      per_column = (sq_eff == 0) ? (nrows + 1) / 2 : nrows * sq_eff;
   endtask

   // pixel side: random stalls, one long hold-off
   initial begin
      int gap;
      int calm;
      int taken;
      calm = 0;
      taken = 0;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap(calm);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         taken++;
      end
   end

   // stimulus and verdict
   initial begin
      int per_column;
      int count;
      req_ch.valid <= 1'b0;
      req_ch.magnitude <= '0;
      req_ch.max_ampl <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_ROWS;
      csr_ch.data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings, zero limit and full scale
      offer_bin('0, '0);
      offer_bin('1, '1);
      offer_bin('1, 15'd1);
      offer_bin(16'h8000, 15'h4000);

      // rows lowered below the current row
      settle();
      write_reg(REG_ROWS, 16'd2);
      offer_bin(16'h1234, 15'd100);
      offer_bin('0, '1);

      // squeeze zero with odd rows, black grid
      settle();
      write_reg(REG_SQUEEZE, 16'd0);
      write_reg(REG_ROWS, 16'd3);
      write_reg(REG_GRID_COLOR, 16'h0000);
      offer_bin('1, '1);
      offer_bin('0, '0);

      // squeeze lowered in the middle of a row
      settle();
      write_reg(REG_SQUEEZE, 16'd3);
      offer_bin(16'd100, 15'd50);
      settle();
      write_reg(REG_SQUEEZE, 16'd1);
      offer_bin(16'd200, 15'd50);

      // partial sum dropped by squeeze zero
      settle();
      write_reg(REG_SQUEEZE, 16'd2);
      offer_bin(16'd300, 15'd10);
      settle();
      write_reg(REG_SQUEEZE, 16'd0);
      offer_bin(16'd5, 15'd10);

      // squeeze above four and rows zero
      settle();
      write_reg(REG_SQUEEZE, 16'd7);
      write_reg(REG_ROWS, 16'd0);
      write_reg(REG_GRID_COLOR, 16'hFFFF);
      repeat (4) offer_bin('1, '1);

      // narrow plot, then rows above the maximum
      settle();
      write_reg(REG_PLOT_WIDTH, 16'd20);
      write_reg(REG_ROWS, 16'd1);
      write_reg(REG_SQUEEZE, 16'd1);
      offer_bin(16'd7, 15'd3);
      offer_bin(16'hFFFE, 15'h7FFE);
      settle();
      write_reg(REG_PLOT_WIDTH, 16'd21);
      write_reg(REG_ROWS, 16'd511);
      write_reg(REG_SQUEEZE, 16'd0);
      offer_bin(16'h5555, 15'h2AAA);
      offer_bin(16'hAAAA, 15'h5555);

      // random settings, mostly whole columns
      while (sent < ITEM_TARGET) begin
         settle();
         pick_setting(per_column);
         if (per_column <= 30) begin
            count = per_column * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 3);
         end else begin
            count = $urandom_range(10, 40);
         end
         repeat (count) offer_random_bin();
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
